@@ rtl/pointer_event_queue_macros.svh @@
// assertion macros for the pointer event queue sequencer
`ifndef POINTER_EVENT_QUEUE_MACROS_SVH
`define POINTER_EVENT_QUEUE_MACROS_SVH

// same-cycle implication, held off during reset
`define PEQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define PEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/peq_pkg.sv @@
// types and constants of the pointer event queue
`default_nettype none

package peq_pkg;

   // default number of queue entries
   localparam int QUEUE_DEPTH_DEF = 64;

   // wait mode bits
   localparam int MODE_MOTION_BIT  = 1;
   localparam int MODE_RELEASE_BIT = 2;

   typedef logic [2:0] mode_type;
   typedef logic [6:0] fill_type;
   typedef logic [9:0] window_type;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_TAKE  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   // one incoming item
   typedef struct packed {
      opcode_type         opcode;
      window_type         window;
      logic               any_window;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] button_code;
      logic               is_motion;
      logic               is_release;
      logic               claimed;
   } req_item_type;

   // one result item
   typedef struct packed {
      logic               found;
      window_type         out_window;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [15:0] out_button;
      fill_type           fill_level;
   } rsp_item_type;

   // one stored event
   typedef struct packed {
      window_type         window;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] button;
      logic               is_motion;
      logic               is_release;
   } entry_type;

endpackage

`default_nettype wire

@@ rtl/peq_store.sv @@
// event store: one write port, one read port, registered read data
`default_nettype none

module peq_store #(
   parameter int DEPTH = peq_pkg::QUEUE_DEPTH_DEF,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire                    clock,
   input  wire                    we,
   input  wire  [PTR_W-1:0]       waddr,
   input  peq_pkg::entry_type     wdata,
   input  wire                    re,
   input  wire  [PTR_W-1:0]       raddr,
   output peq_pkg::entry_type     rdata
);

   peq_pkg::entry_type mem [DEPTH];
   peq_pkg::entry_type rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ rtl/peq_ctrl.sv @@
// queue sequencer: push filter, ring pointers, search and compaction pass
`default_nettype none

module peq_ctrl #(
   parameter int DEPTH = peq_pkg::QUEUE_DEPTH_DEF,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  peq_pkg::req_item_type  req_item,
   input  peq_pkg::mode_type      wait_mode,
   output logic                   rsp_strobe,
   output peq_pkg::rsp_item_type  rsp_item,
   output logic                   mem_we,
   output logic [PTR_W-1:0]       mem_waddr,
   output peq_pkg::entry_type     mem_wdata,
   output logic                   mem_re,
   output logic [PTR_W-1:0]       mem_raddr,
   input  peq_pkg::entry_type     mem_rdata
);

   `include "pointer_event_queue_macros.svh"

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);

   peq_pkg::state_type    state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]      kept_ff, kept_in;
   logic                  pend_ff, pend_in;
   logic                  taken_ff, taken_in;
   logic                  op_clear_ff, op_clear_in;
   logic                  any_ff, any_in;
   peq_pkg::window_type   win_ff, win_in;
   peq_pkg::entry_type    hit_ff, hit_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   peq_pkg::rsp_item_type rsp_ff, rsp_in;

   logic                  accept;
   logic                  admit;
   logic                  match;
   peq_pkg::entry_type    new_entry;
   logic                  in_scan;
   logic                  scan_done;

   // logical slot to physical address on the ring
   function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                             input logic [PTR_W-1:0] idx);
      logic [PTR_W:0] sum;
      sum = {1'b0, head} + {1'b0, idx};
      if (sum >= DEPTH_EXT) begin
         sum = sum - DEPTH_EXT;
      end
      return sum[PTR_W-1:0];
   endfunction

   // push filter by wait mode
   always_comb begin
      if (wait_mode == '0) begin
         admit = !req_item.claimed && !req_item.is_motion && !req_item.is_release;
      end else begin
         admit = (wait_mode[peq_pkg::MODE_MOTION_BIT] && req_item.is_motion) ||
                 (wait_mode[peq_pkg::MODE_RELEASE_BIT] && req_item.is_release) ||
                 (!req_item.is_motion && !req_item.is_release);
      end
   end

   // event as stored
   always_comb begin
      new_entry.window     = req_item.window;
      new_entry.x          = req_item.pos_x;
      new_entry.y          = req_item.pos_y;
      new_entry.button     = req_item.button_code;
      new_entry.is_motion  = req_item.is_motion;
      new_entry.is_release = req_item.is_release;
   end

   assign accept = start && (state_ff == peq_pkg::ST_IDLE);
   assign match  = any_ff || (mem_rdata.window == win_ff);

   // next state, memory access and result
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      rd_idx_in     = rd_idx_ff;
      kept_in       = kept_ff;
      pend_in       = pend_ff;
      taken_in      = taken_ff;
      op_clear_in   = op_clear_ff;
      any_in        = any_ff;
      win_in        = win_ff;
      hit_in        = hit_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = phys(head_ff, kept_ff[PTR_W-1:0]);
      mem_wdata     = mem_rdata;
      mem_re        = 1'b0;
      mem_raddr     = phys(head_ff, rd_idx_ff[PTR_W-1:0]);

      case (state_ff)
         peq_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_in        = '0;
               rsp_strobe_in = 1'b1;
               case (req_item.opcode)
                  peq_pkg::OP_PUSH: begin
                     if (admit) begin
                        mem_we    = 1'b1;
                        mem_wdata = new_entry;
                        if (count_ff == DEPTH_CNT) begin
                           // full: overwrite the oldest entry
                           mem_waddr = head_ff;
                           head_in   = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
                        end else begin
                           mem_waddr = phys(head_ff, count_ff[PTR_W-1:0]);
                           count_in  = count_ff + 1'b1;
                        end
                     end
                  end
                  peq_pkg::OP_TAKE,
                  peq_pkg::OP_CLEAR: begin
                     if ((req_item.opcode == peq_pkg::OP_CLEAR) && req_item.any_window) begin
                        count_in = '0;
                        head_in  = '0;
                     end else if (count_ff != '0) begin
                        // one pass over the held entries
                        rsp_strobe_in = 1'b0;
                        state_in      = peq_pkg::ST_SCAN;
                        rd_idx_in     = '0;
                        kept_in       = '0;
                        pend_in       = 1'b0;
                        taken_in      = 1'b0;
                        op_clear_in   = (req_item.opcode == peq_pkg::OP_CLEAR);
                        any_in        = req_item.any_window;
                        win_in        = req_item.window;
                        hit_in        = '0;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_in.fill_level = peq_pkg::fill_type'(count_in);
            end
         end
         peq_pkg::ST_SCAN: begin
            // read side: one entry a cycle
            if (rd_idx_ff < count_ff) begin
               mem_re    = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            // write side: drop the hit or compact the survivor down
            if (pend_ff) begin
               if (match && (op_clear_ff || !taken_ff)) begin
                  if (!op_clear_ff) begin
                     taken_in = 1'b1;
                     hit_in   = mem_rdata;
                  end
               end else begin
                  mem_we  = 1'b1;
                  kept_in = kept_ff + 1'b1;
               end
            end
            // pass complete
            if (!pend_ff && (rd_idx_ff == count_ff)) begin
               state_in          = peq_pkg::ST_IDLE;
               count_in          = kept_ff;
               rsp_strobe_in     = 1'b1;
               rsp_in.found      = taken_ff;
               rsp_in.out_window = hit_ff.window;
               rsp_in.out_x      = hit_ff.x;
               rsp_in.out_y      = hit_ff.y;
               rsp_in.out_button = hit_ff.button;
               rsp_in.fill_level = peq_pkg::fill_type'(kept_ff);
            end
         end
         default: begin
            state_in = peq_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= peq_pkg::ST_IDLE;
         count_ff      <= '0;
         head_ff       <= '0;
         rd_idx_ff     <= '0;
         kept_ff       <= '0;
         pend_ff       <= 1'b0;
         taken_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         rd_idx_ff     <= rd_idx_in;
         kept_ff       <= kept_in;
         pend_ff       <= pend_in;
         taken_ff      <= taken_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_clear_ff <= op_clear_in;
      any_ff      <= any_in;
      win_ff      <= win_in;
      hit_ff      <= hit_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != peq_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // pass tracking for the checks below
   assign in_scan   = (state_ff == peq_pkg::ST_SCAN);
   assign scan_done = in_scan && (state_in == peq_pkg::ST_IDLE);

   `PEQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_CNT, "count above depth")
   `PEQ_ASSERT_NOW(a_kept, clock, reset, in_scan, kept_ff <= rd_idx_ff, "kept ahead of read")
   `PEQ_ASSERT_NOW(a_ports, clock, reset, mem_we && mem_re, mem_waddr != mem_raddr, "same entry")
   `PEQ_ASSERT_NEXT(a_result, clock, reset, scan_done, rsp_strobe, "pass ended without result")

endmodule

`default_nettype wire

@@ rtl/pointer_event_queue.sv @@
// pointer event queue top level: mode register, sequencer and event store
//
//   port group   direction  handshake
//   req_*        in         start high while busy low
//   rsp_*        out        rsp_strobe for one cycle, always taken
//   csr_*        in         csr_we high, no wait
//
// push, unused opcode, clear of all windows, and take or clear on an empty
// queue: result in the cycle after the item, busy stays low.
// take or clear of one window: one read per held entry through the store's
// single read port, with busy high for the whole pass, result after.
// reset is synchronous; it empties the queue and zeroes the wait mode.
`default_nettype none

module pointer_event_queue #(
   parameter int QUEUE_DEPTH = peq_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  peq_pkg::req_item_type  req_item,
   output logic                   rsp_strobe,
   output peq_pkg::rsp_item_type  rsp_item,
   input  wire                    csr_we,
   input  peq_pkg::mode_type      csr_wdata
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   peq_pkg::mode_type  wait_mode_ff, wait_mode_in;
   logic               mem_we;
   logic [PTR_W-1:0]   mem_waddr;
   peq_pkg::entry_type mem_wdata;
   logic               mem_re;
   logic [PTR_W-1:0]   mem_raddr;
   peq_pkg::entry_type mem_rdata;

   // wait mode register
   assign wait_mode_in = csr_we ? csr_wdata : wait_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_mode_ff <= '0;
      end else begin
         wait_mode_ff <= wait_mode_in;
      end
   end

   // sequencer
   peq_ctrl #(
      .DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .wait_mode  (wait_mode_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   // event store
   peq_store #(
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

`default_nettype wire

@@ sim/tb_pointer_event_queue.sv @@
// testbench for the pointer event queue: directed and random items checked against a predictor
`timescale 1ns / 1ps

import peq_pkg::*;

// predicts the queue contents and the result of each item, then checks results in order
class peq_scoreboard;
   localparam int SLOTS = QUEUE_DEPTH_DEF;

   entry_type    held_events[$];
   rsp_item_type expected_results[$];
   mode_type     wait_mode;

   int unsigned mismatches;
   int unsigned items_noted;
   int unsigned takes_hit;
   int unsigned takes_missed;
   int unsigned clears;
   int unsigned full_drops;
   int unsigned peak_fill;

   function new();
      wait_mode = '0;
      mismatches = 0;
      items_noted = 0;
      takes_hit = 0;
      takes_missed = 0;
      clears = 0;
      full_drops = 0;
      peak_fill = 0;
   endfunction

   function void set_mode(mode_type m);
      wait_mode = m;
   endfunction

   // mode 0 drops claimed, motion and release events; otherwise mode bits admit them
   function bit admits(req_item_type it);
      if (wait_mode == '0)
         return !(it.claimed || it.is_motion || it.is_release);
      return (wait_mode[MODE_MOTION_BIT] && it.is_motion) ||
             (wait_mode[MODE_RELEASE_BIT] && it.is_release) ||
             (!it.is_motion && !it.is_release);
   endfunction

   function void note_item(req_item_type it);
      rsp_item_type res;
      entry_type    ev;
      int           hit;
      int           i;
      res = '0;
      hit = -1;
      items_noted++;
      case (it.opcode)
         OP_PUSH: begin
            if (admits(it)) begin
               ev.window = it.window;
               ev.x = it.pos_x;
               ev.y = it.pos_y;
               ev.button = it.button_code;
               ev.is_motion = it.is_motion;
               ev.is_release = it.is_release;
               // full queue gives up its oldest event
               if (held_events.size() >= SLOTS) begin
                  void'(held_events.pop_front());
                  full_drops++;
               end
               held_events.push_back(ev);
            end
         end
         OP_TAKE: begin
            for (i = 0; i < held_events.size() && hit < 0; i++) begin
               if (it.any_window || held_events[i].window == it.window)
                  hit = i;
            end
            if (hit >= 0) begin
               res.found = 1'b1;
               res.out_window = held_events[hit].window;
               res.out_x = held_events[hit].x;
               res.out_y = held_events[hit].y;
               res.out_button = held_events[hit].button;
               held_events.delete(hit);
               takes_hit++;
            end else begin
               takes_missed++;
            end
         end
         OP_CLEAR: begin
            clears++;
            if (it.any_window) begin
               held_events.delete();
            end else begin
               // walk backwards so the survivors keep their order
               for (i = held_events.size() - 1; i >= 0; i--) begin
                  if (held_events[i].window == it.window)
                     held_events.delete(i);
               end
            end
         end
         default: begin
         end
      endcase
      res.fill_level = fill_type'(held_events.size());
      if (held_events.size() > peak_fill)
         peak_fill = held_events.size();
      expected_results.push_back(res);
   endfunction

   function void report(string field, longint want, longint got);
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatches++;
   endfunction

   function void check_result(rsp_item_type got);
      rsp_item_type want;
      if (expected_results.size() == 0) begin
         $error("result item with no item outstanding");
         mismatches++;
         return;
      end
      want = expected_results.pop_front();
      if (got.found !== want.found)
         report("found", want.found, got.found);
      if (got.out_window !== want.out_window)
         report("out_window", want.out_window, got.out_window);
      if (got.out_x !== want.out_x)
         report("out_x", want.out_x, got.out_x);
      if (got.out_y !== want.out_y)
         report("out_y", want.out_y, got.out_y);
      if (got.out_button !== want.out_button)
         report("out_button", want.out_button, got.out_button);
      if (got.fill_level !== want.fill_level)
         report("fill_level", want.fill_level, got.fill_level);
   endfunction
endclass

module tb_pointer_event_queue;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES = 9;
   // per phase: wait mode, item count, push and clear percentages
   localparam int PHASE_MODE [PHASES]  = '{7, 0, 3, 5, 1, 6, 2, 4, 7};
   localparam int PHASE_ITEMS [PHASES] = '{100, 60, 60, 60, 50, 80, 50, 50, 40};
   localparam int PHASE_PUSH [PHASES]  = '{92, 60, 55, 65, 50, 85, 60, 60, 45};
   localparam int PHASE_CLEAR [PHASES] = '{0, 5, 6, 5, 8, 2, 5, 5, 10};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_strobe;
   rsp_item_type rsp_item;
   logic         csr_we = 1'b0;
   mode_type     csr_wdata = '0;

   peq_scoreboard sb = new();
   window_type    window_pool [4];
   bit            quiet_stretch = 1'b0;
   int unsigned   cycle_count = 0;

   pointer_event_queue dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // monitor: results first, then mode writes, then accepted items
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_result(rsp_item);
         if (csr_we)
            sb.set_mode(csr_wdata);
         if (start && !busy)
            sb.note_item(req_item);
      end
   end

   // present one item after a random gap (none in a quiet stretch) and hold it until accepted
   task automatic send_item(input req_item_type it);
      int gap;
      gap = quiet_stretch ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
   endtask

   // wait for the queue to go quiet, then write the wait mode
   task automatic write_mode(input mode_type m);
      start <= 1'b0;
      do @(posedge clock); while (sb.expected_results.size() != 0 || busy);
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic req_item_type make_push(window_type w, logic signed [15:0] x,
                                              logic signed [15:0] y, logic signed [15:0] b,
                                              bit motion, bit released, bit claimed);
      req_item_type it;
      it = '0;
      it.opcode = OP_PUSH;
      it.window = w;
      it.pos_x = x;
      it.pos_y = y;
      it.button_code = b;
      it.is_motion = motion;
      it.is_release = released;
      it.claimed = claimed;
      return it;
   endfunction

   function automatic req_item_type make_cmd(opcode_type op, window_type w, bit any);
      req_item_type it;
      it = '0;
      it.opcode = op;
      it.window = w;
      it.any_window = any;
      return it;
   endfunction

   // mostly windows from a small pool so that takes and clears find matches
   function automatic window_type pick_window();
      if ($urandom_range(0, 99) < 85)
         return window_pool[$urandom_range(0, 3)];
      return window_type'($urandom_range(0, 1023));
   endfunction

   function automatic req_item_type random_item(int push_pct, int clear_pct);
      req_item_type it;
      int           roll;
      it = {$urandom(), $urandom()};
      roll = $urandom_range(0, 99);
      it.window = pick_window();
      it.is_motion = ($urandom_range(0, 99) < 30);
      it.is_release = ($urandom_range(0, 99) < 30);
      it.claimed = ($urandom_range(0, 99) < 25);
      if (roll < push_pct) begin
         it.opcode = OP_PUSH;
      end else if (roll < push_pct + clear_pct) begin
         it.opcode = OP_CLEAR;
         it.any_window = ($urandom_range(0, 99) < 15);
      end else if (roll >= 98) begin
         it.opcode = OP_NOP;
      end else begin
         it.opcode = OP_TAKE;
         it.any_window = ($urandom_range(0, 99) < 20);
      end
      return it;
   endfunction

   initial begin
      int p;
      int k;
      req_item_type nop_item;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // mode 0 after reset: only unclaimed presses get in
      send_item(make_push(10'd0, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, 1'b0, 1'b0));
      send_item(make_push(10'd1023, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0, 1'b0, 1'b0));
      send_item(make_push(10'd7, 16'sh0001, 16'sh0002, 16'sh0003, 1'b0, 1'b0, 1'b1));
      send_item(make_push(10'd7, 16'sh0004, 16'sh0005, 16'sh0006, 1'b1, 1'b0, 1'b0));
      send_item(make_push(10'd7, 16'sh0007, 16'sh0008, 16'sh0009, 1'b0, 1'b1, 1'b0));
      send_item(make_cmd(OP_TAKE, 10'd1023, 1'b0));
      send_item(make_cmd(OP_TAKE, 10'd5, 1'b0));
      send_item(make_cmd(OP_TAKE, 10'd5, 1'b1));
      send_item(make_cmd(OP_TAKE, 10'd0, 1'b1));
      send_item(make_cmd(OP_CLEAR, 10'd0, 1'b1));
      // unused opcode with every other field set
      nop_item = '1;
      nop_item.opcode = OP_NOP;
      send_item(nop_item);

      // motion and release admitted, claim ignored
      write_mode(mode_type'(6));
      send_item(make_push(10'd3, 16'sh0010, 16'sh0011, 16'sh0012, 1'b1, 1'b0, 1'b1));
      send_item(make_push(10'd4, 16'sh0020, 16'sh0021, 16'sh0022, 1'b0, 1'b1, 1'b0));
      send_item(make_push(10'd3, 16'sh0030, 16'sh0031, 16'sh0032, 1'b1, 1'b1, 1'b0));
      send_item(make_push(10'd3, 16'sh0040, 16'sh0041, 16'shffff, 1'b0, 1'b0, 1'b0));
      send_item(make_push(10'd9, 16'sh0050, 16'sh0051, 16'sh0052, 1'b0, 1'b0, 1'b0));
      // clear of one window keeps the others in order
      send_item(make_cmd(OP_CLEAR, 10'd3, 1'b0));
      send_item(make_cmd(OP_TAKE, 10'd0, 1'b1));
      send_item(make_cmd(OP_CLEAR, 10'd0, 1'b1));

      // motion only
      write_mode(mode_type'(2));
      send_item(make_push(10'd12, 16'sh0060, 16'sh0061, 16'sh0062, 1'b0, 1'b1, 1'b0));
      send_item(make_push(10'd12, 16'sh0070, 16'sh0071, 16'sh0072, 1'b1, 1'b0, 1'b0));
      send_item(make_push(10'd12, 16'sh0080, 16'sh0081, 16'sh0082, 1'b1, 1'b1, 1'b0));

      // release only
      write_mode(mode_type'(4));
      send_item(make_push(10'd13, 16'sh0090, 16'sh0091, 16'sh0092, 1'b1, 1'b0, 1'b0));
      send_item(make_push(10'd13, 16'sh00a0, 16'sh00a1, 16'sh00a2, 1'b0, 1'b1, 1'b0));
      send_item(make_cmd(OP_CLEAR, 10'd1023, 1'b0));

      // random phases, each under its own wait mode and mix
      for (p = 0; p < PHASES; p++) begin
         write_mode(mode_type'(PHASE_MODE[p]));
         for (k = 0; k < 4; k++)
            window_pool[k] = window_type'($urandom_range(0, 1023));
         for (k = 0; k < PHASE_ITEMS[p]; k++) begin
            if ($urandom_range(0, 19) == 0)
               quiet_stretch = !quiet_stretch;
            send_item(random_item(PHASE_PUSH[p], PHASE_CLEAR[p]));
         end
      end

      // drain, then allow for a full scan before the verdict
      start <= 1'b0;
      do @(posedge clock); while (sb.expected_results.size() != 0);
      repeat (QUEUE_DEPTH_DEF + 16) @(posedge clock);

      $display("covered %0d items: %0d takes found, %0d missed, %0d clears",
               sb.items_noted, sb.takes_hit, sb.takes_missed, sb.clears);
      $display("oldest dropped on full queue %0d times, peak fill %0d, %0d mismatches",
               sb.full_drops, sb.peak_fill, sb.mismatches);
      if (sb.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/peq_pkg.sv
rtl/peq_store.sv
rtl/peq_ctrl.sv
rtl/pointer_event_queue.sv
sim/tb_pointer_event_queue.sv
